// ----- src/rgbhsi_pkg.sv -----
// rgbhsi_pkg: types, constants and the arctangent table of the rgb to hsi converter
// no dependencies; imported by rgb_to_hsi_channel, rgb_to_hsi_checker and tb_rgb_to_hsi_channel

package rgbhsi_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    typedef struct packed {
        logic [7:0] level;
        logic       written;
    } lvl_t;

    localparam logic [1:0] CH_HUE = 2'd0;
    localparam logic [1:0] CH_SAT = 2'd1;
    localparam logic [1:0] CH_INT = 2'd2;
    localparam logic [1:0] CH_NONE = 2'd3;

    localparam int HUE_ITERS = 14;
    localparam int CW = 28;
    localparam int ZW = 18;
    localparam int QW = 8;
    localparam int RW = 18;
    localparam int SW = 10;

    localparam logic [16:0] SQRT3_Q15 = 17'd56756;
    localparam logic [15:0] THIRD_Q17 = 16'd43691;
    localparam logic signed [ZW-1:0] QUARTER_TURN = 18'sd16384;
    localparam logic signed [ZW-1:0] HALF_TURN = 18'sd32768;

    localparam logic signed [ZW-1:0] ATAN_TURN16 [HUE_ITERS] = '{
        18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163,
        18'sd81, 18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1
    };

endpackage

// ----- src/rgb_to_hsi_channel.sv -----
// rgb_to_hsi_channel: pipelined rgb to hue / saturation / intensity converter
// depends on rgbhsi_pkg
//
//  port group   direction  handshake           payload
//  in           in         in_valid/in_stall   in_item (red, green, blue)
//  out          out        out_valid/out_stall out_item (level, written)
//  cfg          in         cfg_valid/cfg_ready cfg_data (channel select)
//
// one item per cycle unless the pipe holds; registers in order: prep, 14 cordic stages, output register
// saturation divide runs one quotient bit per stage alongside the first 8 cordic stages
// the whole pipe holds while out_item is valid and stalled
// reset clears valid bits and selects hue; cfg_ready is always high

module rgb_to_hsi_channel (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rgbhsi_pkg::pix_t    in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output rgbhsi_pkg::lvl_t    out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data
);
    import rgbhsi_pkg::*;

    localparam int NS = HUE_ITERS + 1;

    logic [1:0] chan_reg;

    logic signed [CW-1:0] x_reg [NS];
    logic signed [CW-1:0] y_reg [NS];
    logic signed [ZW-1:0] z_reg [NS];
    logic [RW-1:0]        rem_reg [NS];
    logic [QW-1:0]        q_reg [NS];
    logic [SW-1:0]        sum_reg [NS];
    logic [7:0]           ity_reg [NS];
    logic                 grey_reg [NS];
    logic                 bgtg_reg [NS];
    logic                 v_reg [NS];

    logic signed [CW-1:0] x_next [NS];
    logic signed [CW-1:0] y_next [NS];
    logic signed [ZW-1:0] z_next [NS];
    logic [RW-1:0]        rem_next [NS];
    logic [QW-1:0]        q_next [NS];
    logic [SW-1:0]        sum_next [NS];
    logic [7:0]           ity_next [NS];
    logic                 grey_next [NS];
    logic                 bgtg_next [NS];

    lvl_t out_item_reg, out_item_next;
    logic out_valid_reg;
    logic en;

    function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                   input int s);
        logic signed [CW-1:0] m;
        m = -v;
        if (v < 0)
            return -(m >>> s);
        else
            return v >>> s;
    endfunction

    assign en = !(out_valid_reg && out_stall);
    assign in_stall = !en;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item = out_item_reg;

    // prep stage
    logic signed [10:0] d0;
    logic signed [CW-1:0] x0, y0;
    logic [7:0] ad0, mn0;
    logic [24:0] yp0;
    logic [SW-1:0] sum0, t0;
    logic [25:0] ip0;

    always_comb
    begin
        d0 = $signed({2'b00, in_item.red, 1'b0}) - $signed({3'b000, in_item.green})
             - $signed({3'b000, in_item.blue});
        ad0 = (in_item.green > in_item.blue) ? in_item.green - in_item.blue
                                             : in_item.blue - in_item.green;
        yp0 = {17'd0, ad0} * {8'd0, SQRT3_Q15};
        x0 = CW'(d0) <<< 15;
        y0 = $signed({3'b000, yp0});
        if (x0 < 0)
        begin
            x_next[0] = y0;
            y_next[0] = -x0;
            z_next[0] = QUARTER_TURN;
        end
        else
        begin
            x_next[0] = x0;
            y_next[0] = y0;
            z_next[0] = '0;
        end
        mn0 = in_item.red;
        if (in_item.green < mn0)
            mn0 = in_item.green;
        if (in_item.blue < mn0)
            mn0 = in_item.blue;
        sum0 = SW'(in_item.red) + SW'(in_item.green) + SW'(in_item.blue);
        t0 = sum0 - ((SW'(mn0) << 1) + SW'(mn0));
        rem_next[0] = (RW'(t0) << 8) - RW'(t0);
        q_next[0] = '0;
        sum_next[0] = sum0;
        ip0 = {16'd0, sum0} * {10'd0, THIRD_Q17};
        ity_next[0] = ip0[24:17];
        grey_next[0] = (in_item.red == in_item.green) && (in_item.green == in_item.blue);
        bgtg_next[0] = in_item.blue > in_item.green;

        // cordic iteration in every stage and one quotient bit in each of the first QW stages
        for (int j = 1; j < NS; j++)
        begin
            if (y_reg[j-1] > 0)
            begin
                x_next[j] = x_reg[j-1] + shr_tz(y_reg[j-1], j - 1);
                y_next[j] = y_reg[j-1] - shr_tz(x_reg[j-1], j - 1);
                z_next[j] = z_reg[j-1] + ATAN_TURN16[j-1];
            end
            else
            begin
                x_next[j] = x_reg[j-1] - shr_tz(y_reg[j-1], j - 1);
                y_next[j] = y_reg[j-1] + shr_tz(x_reg[j-1], j - 1);
                z_next[j] = z_reg[j-1] - ATAN_TURN16[j-1];
            end
            rem_next[j] = rem_reg[j-1];
            q_next[j] = q_reg[j-1];
            if (j <= QW)
            begin
                if ((sum_reg[j-1] != '0)
                    && (rem_reg[j-1] >= (RW'(sum_reg[j-1]) << (QW - j))))
                begin
                    rem_next[j] = rem_reg[j-1] - (RW'(sum_reg[j-1]) << (QW - j));
                    q_next[j][QW-j] = 1'b1;
                end
            end
            sum_next[j] = sum_reg[j-1];
            ity_next[j] = ity_reg[j-1];
            grey_next[j] = grey_reg[j-1];
            bgtg_next[j] = bgtg_reg[j-1];
        end
    end

    // hue word and channel select
    logic [16:0] zc;
    logic [16:0] hw;
    logic [15:0] h;
    logic [23:0] hp;
    logic [7:0] hue;

    always_comb
    begin
        if (z_reg[NS-1] < 0)
            zc = '0;
        else if (z_reg[NS-1] > HALF_TURN)
            zc = 17'(HALF_TURN);
        else
            zc = z_reg[NS-1][16:0];
        hw = bgtg_reg[NS-1] ? 17'h10000 - zc : zc;
        h = hw[16] ? 16'hffff : hw[15:0];
        hp = {8'd0, h} * 24'd255;
        hue = grey_reg[NS-1] ? 8'd0 : hp[23:16];
        unique case (chan_reg)
            CH_HUE:
            begin
                out_item_next.level = hue;
                out_item_next.written = 1'b1;
            end
            CH_SAT:
            begin
                out_item_next.level = q_reg[NS-1];
                out_item_next.written = 1'b1;
            end
            CH_INT:
            begin
                out_item_next.level = ity_reg[NS-1];
                out_item_next.written = 1'b1;
            end
            default:
            begin
                out_item_next.level = '0;
                out_item_next.written = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= CH_HUE;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < NS; j++)
                v_reg[j] <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                chan_reg <= cfg_data;
            if (en)
            begin
                v_reg[0] <= in_valid;
                for (int j = 1; j < NS; j++)
                    v_reg[j] <= v_reg[j-1];
                out_valid_reg <= v_reg[NS-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NS; j++)
            begin
                x_reg[j] <= x_next[j];
                y_reg[j] <= y_next[j];
                z_reg[j] <= z_next[j];
                rem_reg[j] <= rem_next[j];
                q_reg[j] <= q_next[j];
                sum_reg[j] <= sum_next[j];
                ity_reg[j] <= ity_next[j];
                grey_reg[j] <= grey_next[j];
                bgtg_reg[j] <= bgtg_next[j];
            end
            out_item_reg <= out_item_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("pipe held without a waiting item");
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NS-1] && !in_stall) |=> out_valid)
        else $error("item lost at the last stage");
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.written) |-> (out_item.level == 8'd0))
        else $error("level set on an unwritten item");
    a_sel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.written == (chan_reg != CH_NONE)))
        else $error("written flag disagrees with channel select");
`endif

endmodule

// ----- tb/sv/rgb_to_hsi_checker.sv -----
// rgb_to_hsi_checker: watches the pixel, level and select channels of rgb_to_hsi_channel,
// predicts each level from the accepted pixels and compares in order
// depends on rgbhsi_pkg
`timescale 1ns / 100ps

module rgb_to_hsi_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  rgbhsi_pkg::pix_t  in_item,
    input  logic              out_valid,
    input  logic              out_stall,
    input  rgbhsi_pkg::lvl_t  out_item,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_data,
    output int                mismatches,
    output int                pending
);
    import rgbhsi_pkg::*;

    logic [1:0] sel_copy;
    lvl_t       level_queue[$];

    localparam longint TURN_TABLE [14] = '{
        8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1
    };

    function automatic longint shift_toward_zero(longint v, int s);
        if (v < 0)
        begin
            return -((-v) >>> s);
        end
        return v >>> s;
    endfunction

    function automatic logic [7:0] hue_of(longint r, longint g, longint b);
        longint xs, ys, x, y, z, nx, ny, h;
        if (r == g && g == b)
        begin
            return 8'd0;
        end
        xs = (2 * r - g - b) * 32768;
        ys = ((g > b) ? g - b : b - g) * 56756;
        if (xs < 0)
        begin
            x = ys;
            y = -xs;
            z = 16384;
        end
        else
        begin
            x = xs;
            y = ys;
            z = 0;
        end
        for (int i = 0; i < 14; i++)
        begin
            if (y > 0)
            begin
                nx = x + shift_toward_zero(y, i);
                ny = y - shift_toward_zero(x, i);
                z = z + TURN_TABLE[i];
            end
            else
            begin
                nx = x - shift_toward_zero(y, i);
                ny = y + shift_toward_zero(x, i);
                z = z - TURN_TABLE[i];
            end
            x = nx;
            y = ny;
        end
        if (z < 0)
        begin
            z = 0;
        end
        if (z > 32768)
        begin
            z = 32768;
        end
        h = (b > g) ? 65536 - z : z;
        if (h > 65535)
        begin
            h = 65535;
        end
        return 8'((h * 255) >> 16);
    endfunction

    function automatic lvl_t predict_level(pix_t p, logic [1:0] sel);
        lvl_t   res;
        longint r, g, b, total, lowest;
        r = p.red;
        g = p.green;
        b = p.blue;
        total = r + g + b;
        lowest = r;
        if (g < lowest)
        begin
            lowest = g;
        end
        if (b < lowest)
        begin
            lowest = b;
        end
        res.written = 1'b1;
        case (sel)
            CH_HUE:  res.level = hue_of(r, g, b);
            CH_SAT:  res.level = (total == 0) ? 8'd0 : 8'((255 * (total - 3 * lowest)) / total);
            CH_INT:  res.level = 8'(total / 3);
            default:
            begin
                res.level = 8'd0;
                res.written = 1'b0;
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lvl_t want;
        if (!rst_n)
        begin
            sel_copy <= CH_HUE;
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                sel_copy <= cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                level_queue.push_back(predict_level(in_item, sel_copy));
            end
            if (out_valid && !out_stall)
            begin
                if (level_queue.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("unexpected level item: level %0d written %0b",
                                 out_item.level, out_item.written);
                    end
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = level_queue.pop_front();
                    if (want.level !== out_item.level || want.written !== out_item.written)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("level mismatch: expected level %0d written %0b, got %0d %0b",
                                     want.level, want.written, out_item.level, out_item.written);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= level_queue.size();
        end
    end

endmodule

// ----- tb/sv/tb_rgb_to_hsi_channel.sv -----
// tb_rgb_to_hsi_channel: drives pixels and channel selects into rgb_to_hsi_channel
// with random idling on both sides; depends on rgbhsi_pkg and rgb_to_hsi_checker
`timescale 1ns / 100ps

module tb_rgb_to_hsi_channel;
    import rgbhsi_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    pix_t       in_item;
    logic       out_valid;
    logic       out_stall;
    lvl_t       out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;
    int         mismatches;
    int         pending;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         quiet_cycles;

    rgb_to_hsi_channel dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    rgb_to_hsi_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .mismatches(mismatches), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= 20000)
        begin
            $display("tb_rgb_to_hsi_channel: FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{red: r, green: g, blue: b};
        do
        begin
            @(posedge clk);
        end
        while (!(in_valid && !in_stall));
    endtask

    task automatic select_channel(logic [1:0] sel);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_data <= sel;
        do
        begin
            @(posedge clk);
        end
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_pixel();
        logic [7:0] r, g, b;
        int         kind;
        kind = $urandom_range(9);
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        if (kind == 0)
        begin
            g = r;
            b = r;
        end
        else if (kind == 1)
        begin
            g = 8'(r + $urandom_range(2) - 1);
            b = 8'(r + $urandom_range(2) - 1);
        end
        else if (kind == 2)
        begin
            r = $urandom_range(1) ? 8'hff : 8'h00;
            g = $urandom_range(1) ? 8'hff : 8'h00;
        end
        else if (kind == 3)
        begin
            g = b;
        end
        send_pixel(r, g, b);
    endtask

    localparam logic [1:0] SEL_ORDER [4] = '{CH_HUE, CH_SAT, CH_INT, CH_NONE};

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_data = CH_HUE;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int s = 0; s < 4; s++)
        begin
            select_channel(SEL_ORDER[s]);
            send_pixel(8'd0, 8'd0, 8'd0);
            send_pixel(8'd255, 8'd255, 8'd255);
            send_pixel(8'd128, 8'd128, 8'd128);
            send_pixel(8'd255, 8'd0, 8'd0);
            send_pixel(8'd0, 8'd255, 8'd0);
            send_pixel(8'd0, 8'd0, 8'd255);
            send_pixel(8'd0, 8'd255, 8'd255);
            send_pixel(8'd255, 8'd0, 8'd255);
            send_pixel(8'd0, 8'd1, 8'd2);
            send_pixel(8'd0, 8'd2, 8'd1);
            send_pixel(8'd1, 8'd0, 8'd0);
            send_pixel(8'd254, 8'd255, 8'd255);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 74 : 0;
            recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 13 : 0;
            for (int blk = 0; blk < 8; blk++)
            begin
                select_channel((blk < 4) ? SEL_ORDER[blk] : 2'($urandom_range(3)));
                repeat (65) send_random_pixel();
            end
        end
        in_valid <= 1'b0;

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("tb_rgb_to_hsi_channel: PASS");
        end
        else
        begin
            $display("tb_rgb_to_hsi_channel: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/rgbhsi_pkg.sv
src/rgb_to_hsi_channel.sv
tb/sv/rgb_to_hsi_checker.sv
tb/sv/tb_rgb_to_hsi_channel.sv
